FILE: rtl/core/kpec_pkg.sv
`default_nettype none

package kpec_pkg;

  localparam int NUM_KEYS_DEFAULT = 18;
  localparam int RAW_KEYS         = 18;
  localparam int FLAG_W           = 18;
  localparam int TIME_W           = 32;
  localparam int THR_W            = 16;
  localparam int KB_W             = 16;
  localparam int CFG_IDX_W        = 2;

  localparam logic [THR_W-1:0] HOLD_RESET  = 16'd50;
  localparam logic [THR_W-1:0] LONG_RESET  = 16'd800;
  localparam logic [THR_W-1:0] SHORT_RESET = 16'd300;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HOLD  = 2'd0,
    CFG_LONG  = 2'd1,
    CFG_SHORT = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [THR_W-1:0] hold;
    logic [THR_W-1:0] long_thr;
    logic [THR_W-1:0] short_thr;
  } thresholds_t;

  typedef struct packed {
    logic              valid;
    logic              last;
    logic              cur;
    logic              prev;
    logic [TIME_W-1:0] now;
    logic [FLAG_W-1:0] levels;
  } issue_t;

  typedef struct packed {
    logic              valid;
    logic [FLAG_W-1:0] held_flags;
    logic [FLAG_W-1:0] long_press_flags;
    logic [FLAG_W-1:0] short_press_flags;
    logic [FLAG_W-1:0] key_levels;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/kpec_if.sv
`default_nettype none

interface kpec_in_if;
  logic                        valid;
  logic                        ready;
  logic [kpec_pkg::KB_W-1:0]   keyboard_bits;
  logic                        left_button;
  logic                        right_button;
  logic [kpec_pkg::TIME_W-1:0] now_ms;

  modport source (output valid, keyboard_bits, left_button, right_button, now_ms,
                  input ready);
  modport sink   (input valid, keyboard_bits, left_button, right_button, now_ms,
                  output ready);
endinterface

interface kpec_out_if;
  logic                        valid;
  logic                        ready;
  logic [kpec_pkg::FLAG_W-1:0] held_flags;
  logic [kpec_pkg::FLAG_W-1:0] long_press_flags;
  logic [kpec_pkg::FLAG_W-1:0] short_press_flags;
  logic [kpec_pkg::FLAG_W-1:0] key_levels;

  modport source (output valid, held_flags, long_press_flags, short_press_flags, key_levels,
                  input ready);
  modport sink   (input valid, held_flags, long_press_flags, short_press_flags, key_levels,
                  output ready);
endinterface

interface kpec_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [kpec_pkg::CFG_IDX_W-1:0] index;
  logic [kpec_pkg::THR_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/key_press_event_classifier.sv
// Results pass the key unit's issue register into the output register; a new item
// is accepted as the last key of the current one issues. The press-time RAM is swept
// one key per cycle through its single read port; the last key stalls until output is free.
// A finished result waits in the output register while the next item sweeps.
// Reset (rst, synchronous): thresholds return to 50/800/300 ms, key levels and
// long-press marks clear; press times stay unknown until a press writes them.
`default_nettype none

module key_press_event_classifier #(
  parameter int NUM_KEYS = kpec_pkg::NUM_KEYS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  kpec_in_if.sink    key_in,
  kpec_out_if.source result_out,
  kpec_cfg_if.sink   cfg
);

  localparam int IW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int CW = (NUM_KEYS > kpec_pkg::FLAG_W) ? NUM_KEYS : kpec_pkg::FLAG_W;

  kpec_pkg::thresholds_t thr;
  kpec_pkg::issue_t      iss;
  kpec_pkg::result_t     res;
  kpec_pkg::result_t     out_q;

  logic [kpec_pkg::RAW_KEYS-1:0] raw;
  logic [CW-1:0]                 raw_wide;
  logic [CW-1:0]                 lv_wide;
  logic [NUM_KEYS-1:0]           levels_in;
  logic [NUM_KEYS-1:0]           previous_levels;
  logic [NUM_KEYS-1:0]           it_levels;
  logic [NUM_KEYS-1:0]           it_prev;
  logic [kpec_pkg::TIME_W-1:0]   it_now;
  logic [IW-1:0]                 idx;

  logic active;
  logic last_inflight;
  logic out_valid;
  logic is_last;
  logic out_free;
  logic issue;
  logic accept;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr.hold      <= kpec_pkg::HOLD_RESET;
      thr.long_thr  <= kpec_pkg::LONG_RESET;
      thr.short_thr <= kpec_pkg::SHORT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        kpec_pkg::CFG_HOLD:  thr.hold      <= cfg.data;
        kpec_pkg::CFG_LONG:  thr.long_thr  <= cfg.data;
        kpec_pkg::CFG_SHORT: thr.short_thr <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    raw       = {key_in.keyboard_bits, key_in.right_button, key_in.left_button};
    raw_wide  = CW'(raw);
    levels_in = raw_wide[NUM_KEYS-1:0];
    lv_wide   = CW'(it_levels);
    is_last   = (idx == IW'(NUM_KEYS - 1));
    out_free  = (!out_valid || result_out.ready) && !last_inflight;
    issue     = active && (!is_last || out_free);
    accept    = key_in.valid && key_in.ready;

    iss.valid  = issue;
    iss.last   = is_last;
    iss.cur    = it_levels[idx];
    iss.prev   = it_prev[idx];
    iss.now    = it_now;
    iss.levels = lv_wide[kpec_pkg::FLAG_W-1:0];
  end

  assign key_in.ready = !active || (issue && is_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      active          <= 1'b0;
      previous_levels <= '0;
      last_inflight   <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      last_inflight <= issue && is_last;
      if (accept) begin
        active          <= 1'b1;
        previous_levels <= levels_in;
      end else if (issue && is_last) begin
        active <= 1'b0;
      end
      if (res.valid) begin
        out_valid <= 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      idx       <= '0;
      it_levels <= levels_in;
      it_prev   <= previous_levels;
      it_now    <= key_in.now_ms;
    end else if (issue && !is_last) begin
      idx <= idx + IW'(1);
    end
    if (res.valid) begin
      out_q <= res;
    end
  end

  kpec_key_unit #(
    .NUM_KEYS (NUM_KEYS)
  ) u_key_unit (
    .clk (clk),
    .rst (rst),
    .iss (iss),
    .idx (idx),
    .thr (thr),
    .res (res)
  );

  assign result_out.valid             = out_valid;
  assign result_out.held_flags        = out_q.held_flags;
  assign result_out.long_press_flags  = out_q.long_press_flags;
  assign result_out.short_press_flags = out_q.short_press_flags;
  assign result_out.key_levels        = out_q.key_levels;

  a_out_slot_free: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (!out_valid || result_out.ready))
    else $error("result overwrote a pending transaction");

  a_accept_at_end: assert property (@(posedge clk) disable iff (rst)
    (accept && active) |-> (issue && is_last))
    else $error("item accepted mid-sweep");

  a_sweep_start: assert property (@(posedge clk) disable iff (rst)
    accept |=> (active && (idx == '0)))
    else $error("sweep did not start at first key");

endmodule

`default_nettype wire

FILE: rtl/core/kpec_key_unit.sv
`default_nettype none

module kpec_key_unit #(
  parameter int NUM_KEYS = kpec_pkg::NUM_KEYS_DEFAULT,
  localparam int IW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1,
  localparam int CW = (NUM_KEYS > kpec_pkg::FLAG_W) ? NUM_KEYS : kpec_pkg::FLAG_W
) (
  input  logic                  clk,
  input  logic                  rst,
  input  kpec_pkg::issue_t      iss,
  input  logic [IW-1:0]         idx,
  input  kpec_pkg::thresholds_t thr,
  output kpec_pkg::result_t     res
);

  localparam int TW = kpec_pkg::TIME_W;
  localparam int ZW = kpec_pkg::TIME_W - kpec_pkg::THR_W;

  logic [TW-1:0] start_ram [NUM_KEYS];
  logic [TW-1:0] rd_data;
  logic [TW-1:0] fwd_data;
  logic [TW-1:0] start_time;
  logic [TW-1:0] dur;
  logic          fwd;

  kpec_pkg::issue_t iss_q;
  logic [IW-1:0]    idx_q;

  logic [NUM_KEYS-1:0] long_reported;
  logic [NUM_KEYS-1:0] held_acc, long_acc, short_acc;
  logic [NUM_KEYS-1:0] held_next, long_next, short_next;
  logic [CW-1:0]       held_wide, long_wide, short_wide;

  logic rising, both, falling;
  logic held_hit, long_hit, short_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      iss_q <= '0;
    end else begin
      iss_q <= iss;
    end
    idx_q <= idx;
  end

  always_ff @(posedge clk) begin
    if (iss.valid) begin
      rd_data <= start_ram[idx];
    end
    if (rising) begin
      start_ram[idx_q] <= iss_q.now;
    end
    fwd      <= rising && (idx_q == idx);
    fwd_data <= iss_q.now;
  end

  always_comb begin
    start_time = fwd ? fwd_data : rd_data;
    dur        = iss_q.now - start_time;
    rising     = iss_q.valid && iss_q.cur && !iss_q.prev;
    both       = iss_q.valid && iss_q.cur && iss_q.prev;
    falling    = iss_q.valid && !iss_q.cur && iss_q.prev;
    held_hit   = both && (dur >= {{ZW{1'b0}}, thr.hold});
    long_hit   = both && (dur >= {{ZW{1'b0}}, thr.long_thr}) && !long_reported[idx_q];
    short_hit  = falling && (dur < {{ZW{1'b0}}, thr.short_thr});

    held_next  = held_acc;
    long_next  = long_acc;
    short_next = short_acc;
    held_next[idx_q]  = held_hit;
    long_next[idx_q]  = long_hit;
    short_next[idx_q] = short_hit;

    held_wide  = CW'(held_next);
    long_wide  = CW'(long_next);
    short_wide = CW'(short_next);
  end

  always_ff @(posedge clk) begin
    if (iss_q.valid) begin
      held_acc  <= held_next;
      long_acc  <= long_next;
      short_acc <= short_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      long_reported <= '0;
    end else if (rising) begin
      long_reported[idx_q] <= 1'b0;
    end else if (long_hit) begin
      long_reported[idx_q] <= 1'b1;
    end
  end

  assign res.valid             = iss_q.valid && iss_q.last;
  assign res.held_flags        = held_wide[kpec_pkg::FLAG_W-1:0];
  assign res.long_press_flags  = long_wide[kpec_pkg::FLAG_W-1:0];
  assign res.short_press_flags = short_wide[kpec_pkg::FLAG_W-1:0];
  assign res.key_levels        = iss_q.levels;

  a_long_marks: assert property (@(posedge clk) disable iff (rst)
    long_hit |=> long_reported[$past(idx_q)])
    else $error("long press not marked as reported");

  a_press_clears: assert property (@(posedge clk) disable iff (rst)
    rising |=> !long_reported[$past(idx_q)])
    else $error("press did not clear long-reported mark");

  a_sweep_order: assert property (@(posedge clk) disable iff (rst)
    (iss_q.valid && !iss_q.last) |-> (idx == idx_q + IW'(1)))
    else $error("key sweep skipped a key mid-item");

endmodule

`default_nettype wire

FILE: tb/tb_key_press_event_classifier.sv
module tb_key_press_event_classifier;

  localparam int KEYS = kpec_pkg::NUM_KEYS_DEFAULT;
  localparam int FLAG_W = kpec_pkg::FLAG_W;
  localparam int THR_W = kpec_pkg::THR_W;
  localparam int TIME_W = kpec_pkg::TIME_W;
  localparam int KB_W = kpec_pkg::KB_W;
  localparam int ITEMS_PER_PHASE = 235;
  localparam int PHASES = 8;

  typedef struct packed {
    logic [FLAG_W-1:0] held;
    logic [FLAG_W-1:0] long_press;
    logic [FLAG_W-1:0] short_press;
    logic [FLAG_W-1:0] levels;
  } key_flags_t;

  class press_scoreboard;
    logic [THR_W-1:0]  hold_thr;
    logic [THR_W-1:0]  long_thr;
    logic [THR_W-1:0]  short_thr;
    logic [FLAG_W-1:0] prev_levels;
    logic [FLAG_W-1:0] long_seen;
    logic [TIME_W-1:0] press_start [KEYS];
    key_flags_t        pending [$];
    int                errors;

    function new();
      hold_thr    = kpec_pkg::HOLD_RESET;
      long_thr    = kpec_pkg::LONG_RESET;
      short_thr   = kpec_pkg::SHORT_RESET;
      prev_levels = '0;
      long_seen   = '0;
      errors      = 0;
      foreach (press_start[k]) press_start[k] = '0;
    endfunction

    task report(string msg);
      if (errors < 100) $display("ERROR: %s", msg);
      errors++;
    endtask

    function void set_threshold(kpec_pkg::cfg_reg_t idx, logic [THR_W-1:0] value);
      case (idx)
        kpec_pkg::CFG_HOLD:  hold_thr  = value;
        kpec_pkg::CFG_LONG:  long_thr  = value;
        kpec_pkg::CFG_SHORT: short_thr = value;
        default: ;
      endcase
    endfunction

    function void note_sample(logic [KB_W-1:0] kb, logic lb, logic rb,
                              logic [TIME_W-1:0] now);
      key_flags_t        flags;
      logic [TIME_W-1:0] dur;
      flags = '0;
      flags.levels = {kb, rb, lb};
      for (int k = 0; k < KEYS; k++) begin
        dur = now - press_start[k];
        if (flags.levels[k] && !prev_levels[k]) begin
          press_start[k] = now;
          long_seen[k] = 1'b0;
        end else if (flags.levels[k] && prev_levels[k]) begin
          if (dur >= hold_thr) flags.held[k] = 1'b1;
          if (dur >= long_thr && !long_seen[k]) begin
            flags.long_press[k] = 1'b1;
            long_seen[k] = 1'b1;
          end
        end else if (!flags.levels[k] && prev_levels[k]) begin
          if (dur < short_thr) flags.short_press[k] = 1'b1;
        end
      end
      prev_levels = flags.levels;
      pending.push_back(flags);
    endfunction

    task check_result(key_flags_t got);
      key_flags_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result levels=%h", got.levels));
        return;
      end
      want = pending.pop_front();
      if (got.held !== want.held)
        report($sformatf("held_flags got %h want %h", got.held, want.held));
      if (got.long_press !== want.long_press)
        report($sformatf("long_press_flags got %h want %h", got.long_press,
                         want.long_press));
      if (got.short_press !== want.short_press)
        report($sformatf("short_press_flags got %h want %h", got.short_press,
                         want.short_press));
      if (got.levels !== want.levels)
        report($sformatf("key_levels got %h want %h", got.levels, want.levels));
    endtask
  endclass

  logic clk;
  logic rst;
  bit   idling;
  bit   long_stall;
  logic [TIME_W-1:0] clock_ms;
  press_scoreboard   sb;

  kpec_in_if  key_in();
  kpec_out_if result_out();
  kpec_cfg_if cfg();

  key_press_event_classifier dut (
    .clk        (clk),
    .rst        (rst),
    .key_in     (key_in),
    .result_out (result_out),
    .cfg        (cfg)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && result_out.valid && result_out.ready)
      sb.check_result({result_out.held_flags, result_out.long_press_flags,
                       result_out.short_press_flags, result_out.key_levels});
  end

  initial begin
    result_out.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (long_stall) begin
        result_out.ready <= 1'b0;
        repeat (240) @(posedge clk);
        long_stall = 1'b0;
      end else if (idling && $urandom_range(0, 2) == 0) begin
        result_out.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        result_out.ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  initial begin
    #6000000;
    $display("Some tests failed");
    $finish;
  end

  task automatic send_sample(logic [KB_W-1:0] kb, logic lb, logic rb,
                             logic [TIME_W-1:0] now);
    key_in.valid         <= 1'b1;
    key_in.keyboard_bits <= kb;
    key_in.left_button   <= lb;
    key_in.right_button  <= rb;
    key_in.now_ms        <= now;
    do @(posedge clk); while (!key_in.ready);
    sb.note_sample(kb, lb, rb, now);
    clock_ms = now;
    if (idling && !long_stall && $urandom_range(0, 3) == 0) begin
      key_in.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic send_levels(logic [FLAG_W-1:0] lv, logic [TIME_W-1:0] now);
    send_sample(lv[FLAG_W-1:2], lv[0], lv[1], now);
  endtask

  task automatic wait_drain();
    key_in.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (KEYS + 4) @(posedge clk);
  endtask

  task automatic program_thresholds(logic [THR_W-1:0] h, logic [THR_W-1:0] l,
                                    logic [THR_W-1:0] s);
    kpec_pkg::cfg_reg_t regs [3];
    logic [THR_W-1:0]   vals [3];
    regs = '{kpec_pkg::CFG_HOLD, kpec_pkg::CFG_LONG, kpec_pkg::CFG_SHORT};
    vals = '{h, l, s};
    for (int i = 0; i < 3; i++) begin
      cfg.valid <= 1'b1;
      cfg.index <= regs[i];
      cfg.data  <= vals[i];
      do @(posedge clk); while (!cfg.ready);
      sb.set_threshold(regs[i], vals[i]);
    end
    cfg.valid <= 1'b0;
  endtask

  task automatic random_sample();
    logic [FLAG_W-1:0] lv;
    logic [TIME_W-1:0] step;
    logic [THR_W-1:0]  thr;
    logic [THR_W-1:0]  widest;
    int                k;
    widest = sb.hold_thr;
    if (sb.long_thr > widest) widest = sb.long_thr;
    if (sb.short_thr > widest) widest = sb.short_thr;
    case ($urandom_range(0, 9))
      0:       step = 0;
      1, 2, 3, 4: step = $urandom_range(1, 40);
      5, 6:    step = $urandom_range(0, 2 * widest + 2);
      7: begin
        k = $urandom_range(0, KEYS - 1);
        case ($urandom_range(0, 2))
          0:       thr = sb.hold_thr;
          1:       thr = sb.long_thr;
          default: thr = sb.short_thr;
        endcase
        step = sb.press_start[k] + thr + $urandom_range(0, 2) - 1 - clock_ms;
        if (!sb.prev_levels[k] || step[TIME_W-1]) step = $urandom_range(1, 40);
      end
      8:       step = $urandom;
      default: step = $urandom_range(100, 1000);
    endcase
    lv = sb.prev_levels;
    if ($urandom_range(0, 9) == 0) lv = FLAG_W'($urandom);
    else if ($urandom_range(0, 9) >= 4) lv = lv ^ FLAG_W'($urandom & $urandom & $urandom);
    send_levels(lv, clock_ms + step);
  endtask

  initial begin
    logic [THR_W-1:0] hold_set  [PHASES];
    logic [THR_W-1:0] long_set  [PHASES];
    logic [THR_W-1:0] short_set [PHASES];
    sb = new();
    rst                  = 1'b1;
    idling               = 1'b1;
    long_stall           = 1'b0;
    clock_ms             = '0;
    key_in.valid         = 1'b0;
    key_in.keyboard_bits = '0;
    key_in.left_button   = 1'b0;
    key_in.right_button  = 1'b0;
    key_in.now_ms        = '0;
    cfg.valid            = 1'b0;
    cfg.index            = kpec_pkg::CFG_HOLD;
    cfg.data             = '0;
    hold_set  = '{kpec_pkg::HOLD_RESET, 16'd0, 16'hFFFF, 16'd1, 16'd0, 16'hFFFF,
                  THR_W'($urandom), 16'd10};
    long_set  = '{kpec_pkg::LONG_RESET, 16'd0, 16'hFFFF, 16'd2, 16'hFFFF, 16'd0,
                  THR_W'($urandom), 16'd100};
    short_set = '{kpec_pkg::SHORT_RESET, 16'd0, 16'hFFFF, 16'd1, 16'hFFFF, 16'd0,
                  THR_W'($urandom), 16'd50};
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_sample(16'h0000, 1'b0, 1'b0, 32'd0);
    send_sample(16'hFFFF, 1'b1, 1'b1, 32'd100);
    send_sample(16'hFFFF, 1'b1, 1'b1, 32'd149);
    send_sample(16'hFFFF, 1'b1, 1'b1, 32'd150);
    send_sample(16'hFFFF, 1'b1, 1'b1, 32'd899);
    send_sample(16'hFFFF, 1'b1, 1'b1, 32'd900);
    send_sample(16'hFFFF, 1'b1, 1'b1, 32'd5000);
    send_sample(16'h0000, 1'b0, 1'b0, 32'd5001);
    send_sample(16'h0000, 1'b1, 1'b0, 32'hFFFF_FF80);
    send_sample(16'h0000, 1'b1, 1'b0, 32'h0000_0010);
    send_sample(16'h0000, 1'b0, 1'b0, 32'h0000_00AB);
    send_sample(16'h0000, 1'b0, 1'b1, 32'd1000);
    send_sample(16'h0000, 1'b0, 1'b0, 32'd1300);
    send_sample(16'h0000, 1'b0, 1'b1, 32'd1400);
    send_sample(16'h0000, 1'b0, 1'b0, 32'd1698);
    send_sample(16'hAAAA, 1'b0, 1'b0, 32'd2000);
    send_sample(16'h5555, 1'b0, 1'b0, 32'd2010);
    send_sample(16'h5555, 1'b0, 1'b0, 32'd1990);
    send_sample(16'h5555, 1'b0, 1'b0, 32'd1991);
    send_sample(16'h8001, 1'b1, 1'b0, 32'hFFFF_FFFF);
    send_sample(16'h8001, 1'b1, 1'b0, 32'hFFFF_FFFF);
    send_sample(16'h0000, 1'b0, 1'b0, 32'hFFFF_FFFF);

    for (int p = 0; p < PHASES; p++) begin
      wait_drain();
      if (p != 0) program_thresholds(hold_set[p], long_set[p], short_set[p]);
      if (p == PHASES - 1) idling = 1'b0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ((p == 1 || p == 4) && n == ITEMS_PER_PHASE / 2) long_stall = 1'b1;
        random_sample();
      end
    end
    wait_drain();

    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
